/* src/timed_drive_controller_assert.svh */
// Assertion macros for the timed drive controller.
// Included by the top level; expects a signal named clock and one named reset.
`ifndef TIMED_DRIVE_CONTROLLER_ASSERT_SVH
`define TIMED_DRIVE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define TDC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timed drive controller: same-cycle check failed");

// next-cycle implication
`define TDC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timed drive controller: next-cycle check failed");

`endif

/* src/tdc_pkg.sv */
// Types and constants for the timed drive controller.
// No dependencies; used by tdc_step and timed_drive_controller.
`default_nettype none

package tdc_pkg;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_MOVE     = 2'd1,
      OP_HEADLIGHT = 2'd2,
      OP_ABORT    = 2'd3
   } op_type;

   localparam logic [3:0] ACT_IDLE       = 4'd0;
   localparam logic [3:0] ACT_BRAKE      = 4'd1;
   localparam logic [3:0] ACT_FWD        = 4'd2;
   localparam logic [3:0] ACT_BACK       = 4'd3;
   localparam logic [3:0] ACT_FWD_LEFT   = 4'd4;
   localparam logic [3:0] ACT_FWD_RIGHT  = 4'd5;
   localparam logic [3:0] ACT_BACK_LEFT  = 4'd6;
   localparam logic [3:0] ACT_BACK_RIGHT = 4'd7;
   localparam logic [3:0] ACT_COOLOFF    = 4'd8;

   localparam logic [2:0] LIGHT_ON = 3'd1;

   localparam logic [31:0] TICK_MS    = 32'd10;
   localparam logic [31:0] COOLOFF_MS = 32'd1000;
   localparam logic [6:0]  PWM_STEP   = 7'd10;
   localparam logic [6:0]  PWM_LAST   = 7'd90;

   typedef struct packed {
      op_type      op;
      logic [2:0]  action;
      logic [7:0]  power;
      logic [31:0] duration_ms;
      logic [31:0] cmd_opcode;
      logic [31:0] cmd_seq;
   } req_type;

   typedef struct packed {
      logic        drive_valid;
      logic        forward;
      logic        backward;
      logic        left;
      logic        right;
      logic        light;
      logic        resp_valid;
      logic [31:0] resp_opcode;
      logic [31:0] resp_seq;
      logic        announce_valid;
      logic [3:0]  announce_action;
   } rsp_type;

endpackage

`default_nettype wire

/* src/tdc_step.sv */
// Controller state and the per-word update: move load, tick countdown, cool-off, PWM, headlight, abort, announce.
// Depends on tdc_pkg.
`default_nettype none

module tdc_step (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step_en,
   input  tdc_pkg::req_type    item,
   output tdc_pkg::rsp_type    result
);

   logic [3:0]  action_ff,   action_in;
   logic [31:0] remain_ff,   remain_in;
   logic [7:0]  duty_ff,     duty_in;
   logic [6:0]  phase_ff,    phase_in;
   logic [31:0] opcode_ff,   opcode_in;
   logic [31:0] seq_ff,      seq_in;
   logic        light_ff,    light_in;
   logic        announce_ff, announce_in;

   always_comb begin
      logic        ending;
      logic [3:0]  act;
      logic [31:0] rem;
      logic        ann;
      logic        fwd, bwd, lft, rgt;

      action_in   = action_ff;
      remain_in   = remain_ff;
      duty_in     = duty_ff;
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      seq_in      = seq_ff;
      light_in    = light_ff;
      announce_in = announce_ff;
      result      = '0;

      ending = (remain_ff != '0) && (remain_ff <= tdc_pkg::TICK_MS);
      act    = action_ff;
      rem    = remain_ff;
      ann    = announce_ff;
      fwd    = 1'b0;
      bwd    = 1'b0;
      lft    = 1'b0;
      rgt    = 1'b0;

      unique case (item.op)
         tdc_pkg::OP_TICK: begin
            if (ending && (action_ff == tdc_pkg::ACT_COOLOFF ||
                           action_ff == tdc_pkg::ACT_IDLE)) begin
               result.resp_valid  = 1'b1;
               result.resp_opcode = opcode_ff;
               result.resp_seq    = seq_ff;
               act = tdc_pkg::ACT_IDLE;
               rem = '0;
               ann = 1'b1;
            end else if (ending) begin
               act = tdc_pkg::ACT_COOLOFF;
               rem = tdc_pkg::COOLOFF_MS;
               ann = 1'b1;
            end

            unique case (act)
               tdc_pkg::ACT_BRAKE:      begin fwd = 1'b1; bwd = 1'b1; end
               tdc_pkg::ACT_FWD:        fwd = 1'b1;
               tdc_pkg::ACT_BACK:       bwd = 1'b1;
               tdc_pkg::ACT_FWD_LEFT:   begin fwd = 1'b1; lft = 1'b1; end
               tdc_pkg::ACT_FWD_RIGHT:  begin fwd = 1'b1; rgt = 1'b1; end
               tdc_pkg::ACT_BACK_LEFT:  begin bwd = 1'b1; lft = 1'b1; end
               tdc_pkg::ACT_BACK_RIGHT: begin bwd = 1'b1; rgt = 1'b1; end
               default: ;
            endcase

            // duty gate: phase walks 0,10,..,90 so duty of 100+ is always on
            if ({1'b0, phase_ff} >= duty_ff) begin
               fwd = 1'b0;
               bwd = 1'b0;
            end
            phase_in = (phase_ff == tdc_pkg::PWM_LAST) ? '0 : phase_ff + tdc_pkg::PWM_STEP;

            result.drive_valid = 1'b1;
            result.forward     = fwd;
            result.backward    = bwd;
            result.left        = lft;
            result.right       = rgt;
            result.light       = light_ff;

            if (ann) begin
               result.announce_valid  = 1'b1;
               result.announce_action = act;
            end

            action_in   = act;
            announce_in = 1'b0;
            // sub-step remainders are left alone; they still end the move next tick
            remain_in   = (rem >= tdc_pkg::TICK_MS) ? rem - tdc_pkg::TICK_MS : rem;
         end
         tdc_pkg::OP_MOVE: begin
            announce_in = 1'b1;
            action_in   = {1'b0, item.action};
            remain_in   = item.duration_ms;
            duty_in     = item.power;
            phase_in    = '0;
            opcode_in   = item.cmd_opcode;
            seq_in      = item.cmd_seq;
         end
         tdc_pkg::OP_HEADLIGHT: begin
            light_in           = (item.action == tdc_pkg::LIGHT_ON);
            result.resp_valid  = 1'b1;
            result.resp_opcode = item.cmd_opcode;
            result.resp_seq    = item.cmd_seq;
         end
         tdc_pkg::OP_ABORT: begin
            remain_in          = tdc_pkg::TICK_MS;
            result.resp_valid  = 1'b1;
            result.resp_opcode = item.cmd_opcode;
            result.resp_seq    = item.cmd_seq;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         action_ff   <= tdc_pkg::ACT_IDLE;
         remain_ff   <= '0;
         duty_ff     <= '0;
         phase_ff    <= '0;
         opcode_ff   <= '0;
         seq_ff      <= '0;
         light_ff    <= 1'b0;
         announce_ff <= 1'b0;
      end else if (step_en) begin
         action_ff   <= action_in;
         remain_ff   <= remain_in;
         duty_ff     <= duty_in;
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         seq_ff      <= seq_in;
         light_ff    <= light_in;
         announce_ff <= announce_in;
      end
   end

endmodule

`default_nettype wire

/* src/timed_drive_controller.sv */
// Timed drive controller: request register, step logic, result register.
// Path: an accepted request waits in the request register, then its result is held in the
// result register; a stalled result holds the request in the request register.
// Throughput: one word per cycle while the result is not stalled; the step logic is a single
// pass of compares and a 32-bit decrement between the two registers.
// Reset: synchronous, active high; clears both valid bits and all controller state.
`default_nettype none
`include "timed_drive_controller_assert.svh"

module timed_drive_controller (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  tdc_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output tdc_pkg::rsp_type    rsp_data
);

   logic              in_valid_ff, in_valid_in;
   tdc_pkg::req_type  in_ff;
   logic              out_valid_ff, out_valid_in;
   tdc_pkg::rsp_type  out_ff;
   tdc_pkg::rsp_type  step_result;
   logic              out_ready;
   logic              advance;
   logic              req_take;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = out_ready ? advance : out_valid_ff;

   tdc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `TDC_ASSERT_IMPL(a_stall_only_when_full, req_stall, in_valid_ff && rsp_valid && rsp_stall)
   `TDC_ASSERT_NEXT(a_advance_gives_result, advance, rsp_valid)
   `TDC_ASSERT_IMPL(a_announce_on_tick, rsp_valid && rsp_data.announce_valid, rsp_data.drive_valid)

endmodule

`default_nettype wire
